### hdl/brb_pkg.sv
// brb_pkg: shared constants of the pressure-coupling box rescale block
// used by the top level and by its port checker; no dependencies

package brb_pkg;

  // stream payload widths
  localparam int S_DATA_W = 312;
  localparam int M_DATA_W = 136;

  // result field positions in m_tdata
  localparam int RES_Y_LSB = 32;
  localparam int RES_Z_LSB = 64;
  localparam int SCALE_LSB = 96;
  localparam int STATUS_LSB = 128;

  // configuration register indexes
  localparam logic [1:0] CFG_BETA = 2'd0;
  localparam logic [1:0] CFG_DT = 2'd1;
  localparam logic [1:0] CFG_TAU = 2'd2;
  localparam logic [1:0] CFG_TARGET = 2'd3;

  // configuration reset values
  localparam logic [47:0] BETA_RST = 48'd12666373952;
  localparam logic [31:0] DT_RST = 32'd16777;
  localparam logic [31:0] TAU_RST = 32'd65536;
  localparam logic [39:0] TARGET_RST = 40'd65536;

  // status codes
  localparam logic [1:0] ST_SCALED = 2'd0;
  localparam logic [1:0] ST_NO_ATOMS = 2'd1;
  localparam logic [1:0] ST_SMALL_VOL = 2'd2;
  localparam logic [1:0] ST_NONPOS = 2'd3;

  // arithmetic constants
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] K_BAR_Q16 = 64'd105000247886;
  localparam logic [63:0] PRES_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TERM_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] NEWTON_CAP = 64'h0000_0100_0000_0000;
  localparam logic [63:0] CAP_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] M32 = 64'h0000_0000_FFFF_FFFF;
  // ceil(2^44 / 3): exact floor(n / 3) as (n * RECIP3) >> 44 for n below 2^43
  localparam logic [63:0] RECIP3 = 64'd5864062014806;

endpackage

### hdl/berendsen_box_rescale.sv
// berendsen_box_rescale: pressure-coupling box rescale factor and coordinate scaling
// one shared 32x32 multiplier and one bit-serial divider under a one-hot sequencer
// depends on brb_pkg
//
//  channel  | dir | transfer when       | contents
//  s_*      | in  | s_tvalid & s_tready | tuser req_type, tdata box step or coordinate
//  m_*      | out | m_tvalid & m_tready | tdata result x/y/z, scale, status
//  cfg_*    | in  | cfg_wr              | register index and value, no read-back
//
// a coordinate item goes through accept, four multiplier slots and output load
// a box step: volume products, pressure division, beta * dt product, gain division,
//   term product, leading one scan, CBRT_ITERATIONS Newton steps, scaling, output
// one item at a time; s_tready is high only while the sequencer is idle
// a finished result may wait in the output register while the next item is taken
// rst is synchronous; it clears control, restores the registers and mu = 1.0

module berendsen_box_rescale
  import brb_pkg::*;
#(
  parameter int CBRT_ITERATIONS = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // atom_count, len_x, len_y, len_z, twice_kinetic, virial_sum, coord_x, coord_y, coord_z
  input  logic [S_DATA_W-1:0] s_tdata,
  // req_type
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // result_x, result_y, result_z, scale_out, status
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_wr,
  input  logic [1:0]          cfg_addr,
  input  logic [47:0]         cfg_data
);

  localparam int EXTRA_P = 2 * FRAC_BITS;
  localparam int DK_W = $clog2(128 + EXTRA_P);
  localparam int IT_W = $clog2(CBRT_ITERATIONS + 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_WMUL  = 17'h00002,
    S_DIV   = 17'h00004,
    S_V2    = 17'h00008,
    S_V3    = 17'h00010,
    S_P1    = 17'h00020,
    S_P2    = 17'h00040,
    S_G1    = 17'h00080,
    S_G2    = 17'h00100,
    S_T1    = 17'h00200,
    S_SCAN  = 17'h00400,
    S_N1    = 17'h00800,
    S_N2    = 17'h01000,
    S_N3    = 17'h02000,
    S_N4    = 17'h04000,
    S_SCALE = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  state_t state, ret;

  // configuration
  logic [47:0] beta;
  logic [31:0] dt;
  logic [31:0] tau;
  logic [39:0] target;

  // item registers
  logic        is_coord;
  logic [30:0] len [3];
  logic [31:0] cmag [3];
  logic        cneg [3];
  logic [49:0] smag;
  logic        s_neg;
  logic [31:0] stored_factor;
  logic [31:0] x;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // wide multiply sequencing
  logic [63:0]  wa, wb;
  logic [2:0]   wk, wkm;
  logic [127:0] acc, pp_sh;

  // divider
  logic [127:0]    dnum;
  logic [95:0]     dden, drem;
  logic [63:0]     dq, dcap;
  logic [DK_W-1:0] dk, dextra;
  logic            din, dge, dsat;
  logic [96:0]     rem_sh, rem_sub;

  // pressure and factor
  logic [63:0] adiff;
  logic        diff_pos;
  logic signed [63:0] p_val, diff;
  logic        t_big;
  logic [63:0] t_raw, t_val;
  logic [63:0] mu3;
  logic [5:0]  e;
  logic [4:0]  third;
  logic [1:0]  phase;
  logic [IT_W-1:0] it;
  logic [39:0] q3;

  // scaling and results
  logic [1:0]  sc, sc_m1;
  logic [33:0] r_ax;
  logic [31:0] ax_res;
  logic [31:0] res [3];
  logic [31:0] res_scale;
  logic [1:0]  res_status;

  // input views
  logic [23:0] in_atoms;
  logic [30:0] in_len [3];
  logic [47:0] in_tk, in_vir;
  logic [31:0] in_c [3];
  logic signed [49:0] in_sum;

  assign in_atoms  = s_tdata[23:0];
  assign in_len[0] = s_tdata[54:24];
  assign in_len[1] = s_tdata[85:55];
  assign in_len[2] = s_tdata[116:86];
  assign in_tk     = s_tdata[164:117];
  assign in_vir    = s_tdata[212:165];
  assign in_c[0]   = s_tdata[244:213];
  assign in_c[1]   = s_tdata[276:245];
  assign in_c[2]   = s_tdata[308:277];
  assign in_sum    = $signed({2'b00, in_tk}) + $signed({{2{in_vir[47]}}, in_vir});

  assign s_tready = (state == S_IDLE);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_WMUL: begin
        mul_a = wk[0] ? wa[63:32] : wa[31:0];
        mul_b = wk[1] ? wb[63:32] : wb[31:0];
      end
      S_N1: begin
        mul_a = x;
        mul_b = x;
      end
      S_SCALE: begin
        mul_a = is_coord ? cmag[sc] : {1'b0, len[sc]};
        mul_b = x;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // partial product placement
  assign wkm = wk - 3'd1;
  always_comb begin
    case ({1'b0, wkm[0]} + {1'b0, wkm[1]})
      2'd0:    pp_sh = {64'd0, prod};
      2'd1:    pp_sh = {32'd0, prod, 32'd0};
      default: pp_sh = {prod, 64'd0};
    endcase
  end

  // divider step
  assign din     = (dk >= dextra) ? dnum[127] : 1'b0;
  assign rem_sh  = {drem, din};
  assign dge     = rem_sh >= {1'b0, dden};
  assign rem_sub = rem_sh - {1'b0, dden};
  assign dsat    = dq > ((dcap - {63'd0, dge}) >> 1);

  // pressure difference
  assign p_val = s_neg ? -$signed(dq) : $signed(dq);
  assign diff  = $signed({{24{target[39]}}, target}) - p_val;

  // scaled term
  assign t_big = |acc[127:76];
  assign t_raw = acc[75:12];
  assign t_val = (t_big || (t_raw > TERM_CAP)) ? TERM_CAP : t_raw;

  // newton step quotient by three from the reciprocal product
  assign q3 = acc[83:44];

  // one axis of scaling with saturation
  assign sc_m1 = sc - 2'd1;
  assign r_ax  = prod[63:30];
  always_comb begin
    if (is_coord && cneg[sc_m1]) begin
      ax_res = (r_ax > 34'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - r_ax[31:0];
    end else begin
      ax_res = (r_ax > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_ax[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      beta   <= BETA_RST;
      dt     <= DT_RST;
      tau    <= TAU_RST;
      target <= TARGET_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        CFG_BETA:   beta   <= cfg_data;
        CFG_DT:     dt     <= cfg_data[31:0];
        CFG_TAU:    tau    <= cfg_data[31:0];
        CFG_TARGET: target <= cfg_data[39:0];
        default:    beta   <= beta;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret           <= S_IDLE;
      m_tvalid      <= 1'b0;
      stored_factor <= ONE_Q30;
    end else begin
      // output transfer frees the register unless a new result loads it
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            is_coord <= s_tuser;
            for (int i = 0; i < 3; i++) begin
              len[i]  <= in_len[i];
              cneg[i] <= in_c[i][31];
              cmag[i] <= in_c[i][31] ? 32'd0 - in_c[i] : in_c[i];
            end
            s_neg <= in_sum[49];
            smag  <= in_sum[49] ? 50'd0 - in_sum : in_sum;
            if (s_tuser) begin
              x     <= stored_factor;
              sc    <= 2'd0;
              state <= S_SCALE;
            end else if (in_atoms == 24'd0 || in_len[0] == 31'd0 ||
                         in_len[1] == 31'd0 || in_len[2] == 31'd0) begin
              for (int i = 0; i < 3; i++) begin
                res[i] <= {1'b0, in_len[i]};
              end
              res_scale     <= ONE_Q30;
              res_status    <= (in_atoms == 24'd0) ? ST_NO_ATOMS : ST_SMALL_VOL;
              stored_factor <= ONE_Q30;
              state         <= S_OUT;
            end else begin
              wa    <= {33'd0, in_len[0]};
              wb    <= {33'd0, in_len[1]};
              wk    <= 3'd0;
              ret   <= S_V2;
              state <= S_WMUL;
            end
          end
        end
        // four partial products, accumulated one slot behind
        S_WMUL: begin
          if (wk == 3'd0) begin
            acc <= '0;
          end else begin
            acc <= acc + pp_sh;
          end
          if (wk == 3'd4) begin
            state <= ret;
          end else begin
            wk <= wk + 3'd1;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (dk >= dextra) begin
            dnum <= dnum << 1;
          end
          drem <= dge ? rem_sub[95:0] : rem_sh[95:0];
          if (dsat) begin
            dq    <= dcap;
            state <= ret;
          end else begin
            dq <= {dq[62:0], dge};
            if (dk == '0) begin
              state <= ret;
            end else begin
              dk <= dk - 1'b1;
            end
          end
        end
        // volume times length z
        S_V2: begin
          wa    <= acc[63:0];
          wb    <= {33'd0, len[2]};
          wk    <= 3'd0;
          ret   <= S_V3;
          state <= S_WMUL;
        end
        // three times the volume, then |S| * K
        S_V3: begin
          dden  <= 96'(acc + (acc << 1));
          wa    <= {14'd0, smag};
          wb    <= K_BAR_Q16;
          wk    <= 3'd0;
          ret   <= S_P1;
          state <= S_WMUL;
        end
        // pressure magnitude
        S_P1: begin
          dnum   <= acc;
          dextra <= DK_W'(EXTRA_P);
          dcap   <= PRES_CAP;
          drem   <= '0;
          dq     <= '0;
          dk     <= DK_W'(127 + EXTRA_P);
          ret    <= S_P2;
          state  <= S_DIV;
        end
        // pressure difference, then beta * dt
        S_P2: begin
          adiff    <= diff[63] ? 64'd0 - diff : diff;
          diff_pos <= !diff[63] && (diff != 64'sd0);
          wa       <= {16'd0, beta};
          wb       <= {32'd0, dt};
          wk       <= 3'd0;
          ret      <= S_G1;
          state    <= S_WMUL;
        end
        // gain over coupling time
        S_G1: begin
          dnum   <= acc;
          dden   <= {64'd0, tau};
          dextra <= '0;
          dcap   <= CAP_MAX;
          drem   <= '0;
          dq     <= '0;
          dk     <= DK_W'(127);
          ret    <= S_G2;
          state  <= S_DIV;
        end
        S_G2: begin
          wa    <= dq;
          wb    <= adiff;
          wk    <= 3'd0;
          ret   <= S_T1;
          state <= S_WMUL;
        end
        // mu cubed, or the nonpositive skip
        S_T1: begin
          if (diff_pos && (t_val >= ONE_Q60)) begin
            for (int i = 0; i < 3; i++) begin
              res[i] <= {1'b0, len[i]};
            end
            res_scale     <= ONE_Q30;
            res_status    <= ST_NONPOS;
            stored_factor <= ONE_Q30;
            state         <= S_OUT;
          end else begin
            mu3   <= diff_pos ? ONE_Q60 - t_val : ONE_Q60 + t_val;
            e     <= 6'd63;
            third <= 5'd22;
            phase <= 2'd0;
            state <= S_SCAN;
          end
        end
        // leading one search for the cube root seed
        S_SCAN: begin
          if (mu3[e] || e == 6'd0) begin
            x     <= 32'd1 << (6'd10 + {1'b0, third});
            it    <= '0;
            state <= S_N1;
          end else begin
            e <= e - 6'd1;
            if (phase == 2'd0) begin
              third <= third - 5'd1;
              phase <= 2'd2;
            end else begin
              phase <= phase - 2'd1;
            end
          end
        end
        // x squared on the multiplier
        S_N1: begin
          state <= S_N2;
        end
        S_N2: begin
          dnum   <= {64'd0, mu3};
          dden   <= {32'd0, prod};
          dextra <= DK_W'(30);
          dcap   <= NEWTON_CAP;
          drem   <= '0;
          dq     <= '0;
          dk     <= DK_W'(127 + 30);
          ret    <= S_N3;
          state  <= S_DIV;
        end
        // (2x + q) / 3 by reciprocal multiplication
        S_N3: begin
          wa    <= {23'd0, {8'd0, x, 1'b0} + dq[40:0]};
          wb    <= RECIP3;
          wk    <= 3'd0;
          ret   <= S_N4;
          state <= S_WMUL;
        end
        S_N4: begin
          if (q3 == 40'd0) begin
            x <= 32'd1;
          end else if (q3 > 40'h00_FFFF_FFFF) begin
            x <= 32'hFFFF_FFFF;
          end else begin
            x <= q3[31:0];
          end
          if (it == IT_W'(CBRT_ITERATIONS - 1)) begin
            sc    <= 2'd0;
            state <= S_SCALE;
          end else begin
            it    <= it + 1'b1;
            state <= S_N1;
          end
        end
        // three axes through the multiplier
        S_SCALE: begin
          if (sc != 2'd0) begin
            res[sc_m1] <= ax_res;
          end
          if (sc == 2'd3) begin
            res_scale  <= x;
            res_status <= ST_SCALED;
            if (!is_coord) begin
              stored_factor <= x;
            end
            state <= S_OUT;
          end else begin
            sc <= sc + 2'd1;
          end
        end
        // load the output register once it is free
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, res_status, res_scale, res[2], res[1], res[0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/brb_check.sv
// brb_check: port-level checks of the box rescale block, bound to the top level
// depends on brb_pkg

module brb_check
  import brb_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // a skipped box step reports mu = 1.0
  a_skip_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STATUS_LSB +: 2] != ST_SCALED)
      |-> m_tdata[SCALE_LSB +: 32] == ONE_Q30)
    else $error("skip without unit factor");

  // a skipped box step returns the unchanged 31-bit lengths
  a_skip_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STATUS_LSB +: 2] != ST_SCALED)
      |-> !m_tdata[31] && !m_tdata[RES_Y_LSB + 31] && !m_tdata[RES_Z_LSB + 31])
    else $error("skip with out-of-range length");

endmodule

bind berendsen_box_rescale brb_check u_brb_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
